// ===== src/vlos_pkg.sv =====
// ============================================================================
// vlos_pkg
// Shared widths, types and codes of the voxel line-of-sight checker.
// ============================================================================
package vlos_pkg;

   // Coordinate field widths
   localparam int X_W = 6;
   localparam int Y_W = 6;
   localparam int Z_W = 5;

   // Occupancy map organization: one row of X voxels per (y, z) pair
   localparam int ROW_AW = Y_W + Z_W;
   localparam int ROW_W  = 1 << X_W;

   // Axis distances and Bresenham error terms
   localparam int D_W   = X_W;
   localparam int ERR_W = D_W + 4;

   typedef logic [X_W-1:0]          x_type;
   typedef logic [Y_W-1:0]          y_type;
   typedef logic [Z_W-1:0]          z_type;
   typedef logic [D_W-1:0]          dist_type;
   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic [ROW_AW-1:0]       row_addr_type;
   typedef logic [ROW_W-1:0]        row_type;

   // Request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Dominant axis of a walk
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Controller to stepper
   typedef struct packed {
      logic load;
      logic step;
   } walk_ctrl_type;

   // Stepper to controller
   typedef struct packed {
      x_type x;
      y_type y;
      z_type z;
      logic  done;
   } walk_stat_type;

endpackage

// ===== src/vlos_req_if.sv =====
// ============================================================================
// vlos_req_if
// Request channel: voxel writes and line-of-sight queries.
// ============================================================================
interface vlos_req_if;
   import vlos_pkg::*;

   logic  valid;
   logic  ready;
   logic  opcode;
   x_type ax;
   y_type ay;
   z_type az;
   x_type bx;
   y_type by;
   z_type bz;
   logic  occupied_bit;

   modport source (
      output valid, opcode, ax, ay, az, bx, by, bz, occupied_bit,
      input  ready
   );

   modport sink (
      input  valid, opcode, ax, ay, az, bx, by, bz, occupied_bit,
      output ready
   );

endinterface

// ===== src/vlos_rsp_if.sv =====
// ============================================================================
// vlos_rsp_if
// Response channel: one visibility bit per query.
// ============================================================================
interface vlos_rsp_if;

   logic valid;
   logic ready;
   logic visible;

   modport source (
      output valid, visible,
      input  ready
   );

   modport sink (
      input  valid, visible,
      output ready
   );

endinterface

// ===== src/vlos_map_ram.sv =====
// ============================================================================
// vlos_map_ram
// Single-port-write, single-port-read occupancy memory, registered read data.
// ============================================================================
module vlos_map_ram #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vlos_walk.sv =====
// ============================================================================
// vlos_walk
// 3D Bresenham stepper: picks the dominant axis on load, then advances one
// voxel per step and counts the voxels left on the line.
// ============================================================================
module vlos_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  vlos_pkg::walk_ctrl_type ctrl,
   input  vlos_pkg::x_type         ax,
   input  vlos_pkg::y_type         ay,
   input  vlos_pkg::z_type         az,
   input  vlos_pkg::x_type         bx,
   input  vlos_pkg::y_type         by,
   input  vlos_pkg::z_type         bz,
   output vlos_pkg::walk_stat_type stat
);
   import vlos_pkg::*;

   axis_type maj_ff, maj_in;
   dist_type dp_ff, dp_in;
   dist_type dq_ff, dq_in;
   dist_type dr_ff, dr_in;
   logic     sx_ff, sx_in;
   logic     sy_ff, sy_in;
   logic     sz_ff, sz_in;
   err_type  e1_ff, e1_in;
   err_type  e2_ff, e2_in;
   dist_type cnt_ff, cnt_in;
   x_type    x_ff, x_in;
   y_type    y_ff, y_in;
   z_type    z_ff, z_in;

   dist_type dx, dy, dz;
   axis_type ld_maj;
   dist_type ld_dp, ld_dq, ld_dr;
   logic     adv1, adv2;
   logic     mv_x, mv_y, mv_z;
   err_type  two_dp, two_dq, two_dr;

   // Set up the walk from the two endpoints
   always_comb begin
      dx = (ax > bx) ? dist_type'(ax - bx) : dist_type'(bx - ax);
      dy = (ay > by) ? dist_type'(ay - by) : dist_type'(by - ay);
      dz = (az > bz) ? dist_type'(az - bz) : dist_type'(bz - az);
      if (dx >= dy && dx >= dz) begin
         ld_maj = AXIS_X;
         ld_dp  = dx;
         ld_dq  = dy;
         ld_dr  = dz;
      end else if (dy >= dz) begin
         ld_maj = AXIS_Y;
         ld_dp  = dy;
         ld_dq  = dx;
         ld_dr  = dz;
      end else begin
         ld_maj = AXIS_Z;
         ld_dp  = dz;
         ld_dq  = dy;
         ld_dr  = dx;
      end
   end

   // Advance minor axes on a positive error term
   always_comb begin
      adv1   = !e1_ff[ERR_W-1] && (e1_ff != '0);
      adv2   = !e2_ff[ERR_W-1] && (e2_ff != '0);
      two_dp = err_type'({dp_ff, 1'b0});
      two_dq = err_type'({dq_ff, 1'b0});
      two_dr = err_type'({dr_ff, 1'b0});
      case (maj_ff)
         AXIS_X: begin
            mv_x = 1'b1;
            mv_y = adv1;
            mv_z = adv2;
         end
         AXIS_Y: begin
            mv_x = adv1;
            mv_y = 1'b1;
            mv_z = adv2;
         end
         AXIS_Z: begin
            mv_x = adv2;
            mv_y = adv1;
            mv_z = 1'b1;
         end
         default: begin
            mv_x = 1'b0;
            mv_y = 1'b0;
            mv_z = 1'b0;
         end
      endcase
   end

   // Next state: load, step or hold
   always_comb begin
      maj_in = maj_ff;
      dp_in  = dp_ff;
      dq_in  = dq_ff;
      dr_in  = dr_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sz_in  = sz_ff;
      e1_in  = e1_ff;
      e2_in  = e2_ff;
      cnt_in = cnt_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      if (ctrl.load) begin
         maj_in = ld_maj;
         dp_in  = ld_dp;
         dq_in  = ld_dq;
         dr_in  = ld_dr;
         sx_in  = !(ax < bx);
         sy_in  = !(ay < by);
         sz_in  = !(az < bz);
         e1_in  = err_type'({ld_dq, 1'b0}) - err_type'(ld_dp);
         e2_in  = err_type'({ld_dr, 1'b0}) - err_type'(ld_dp);
         cnt_in = ld_dp;
         x_in   = ax;
         y_in   = ay;
         z_in   = az;
      end else if (ctrl.step) begin
         e1_in  = e1_ff - (adv1 ? two_dp : err_type'(0)) + two_dq;
         e2_in  = e2_ff - (adv2 ? two_dp : err_type'(0)) + two_dr;
         cnt_in = cnt_ff - dist_type'(1);
         if (mv_x) begin
            x_in = sx_ff ? x_ff - x_type'(1) : x_ff + x_type'(1);
         end
         if (mv_y) begin
            y_in = sy_ff ? y_ff - y_type'(1) : y_ff + y_type'(1);
         end
         if (mv_z) begin
            z_in = sz_ff ? z_ff - z_type'(1) : z_ff + z_type'(1);
         end
      end
   end

   // Voxels left on the line
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Position, slopes and error terms
   always_ff @(posedge clock) begin
      maj_ff <= maj_in;
      dp_ff  <= dp_in;
      dq_ff  <= dq_in;
      dr_ff  <= dr_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      sz_ff  <= sz_in;
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign stat = '{x: x_ff, y: y_ff, z: z_ff, done: (cnt_ff == '0)};

endmodule

// ===== src/voxel_line_of_sight_check_core.sv =====
// ============================================================================
// voxel_line_of_sight_check_core
// Write: row read on the request transfer, then modify and write back.
// Query: one row read per cycle (endpoints, then one voxel per step); early
//   out on a hit. The next request is taken only after the response is loaded.
// Reset: synchronous; a clearing pass then zeroes the 2048 map rows with
//   req_ch.ready low.
// ============================================================================
module voxel_line_of_sight_check_core #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 32
) (
   input logic        clock,
   input logic        reset,
   vlos_req_if.sink   req_ch,
   vlos_rsp_if.source rsp_ch
);
   import vlos_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_WR_MOD = 6'b000100,
      ST_Q_END  = 6'b001000,
      ST_Q_WALK = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   row_addr_type clr_ff, clr_in;
   x_type        bx_ff, bx_in;
   y_type        by_ff, by_in;
   z_type        bz_ff, bz_in;
   logic         wbit_ff, wbit_in;
   row_addr_type row_ff, row_in;
   x_type        xsel_ff, xsel_in;
   logic         oob_ff, oob_in;
   logic         chk_ff, chk_in;
   logic         vis_ff, vis_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_visible_ff, rsp_visible_in;

   logic          req_xfer;
   logic          rsp_free;
   logic          rsp_load;
   logic          hit;
   logic          rd_en;
   x_type         rd_x;
   y_type         rd_y;
   z_type         rd_z;
   row_addr_type  rd_addr;
   row_type       rd_row;
   logic          wr_en;
   row_addr_type  wr_addr;
   row_type       wr_data;
   walk_ctrl_type wctl;
   walk_stat_type wstat;

   function automatic logic in_grid(x_type x, y_type y, z_type z);
      return (int'(x) < GRID_X) && (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
   endfunction

   // Occupancy map, one row of voxels along x per (y, z)
   vlos_map_ram #(
      .ADDR_W (ROW_AW),
      .DATA_W (ROW_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Bresenham stepper
   vlos_walk u_walk (
      .clock (clock),
      .reset (reset),
      .ctrl  (wctl),
      .ax    (req_ch.ax),
      .ay    (req_ch.ay),
      .az    (req_ch.az),
      .bx    (req_ch.bx),
      .by    (req_ch.by),
      .bz    (req_ch.bz),
      .stat  (wstat)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rd_addr      = {rd_z, rd_y};

   // Check the voxel whose row arrived this cycle
   assign hit = chk_ff && (oob_ff || rd_row[xsel_ff]);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bz_in    = bz_ff;
      wbit_in  = wbit_ff;
      row_in   = row_ff;
      xsel_in  = xsel_ff;
      oob_in   = oob_ff;
      chk_in   = 1'b0;
      vis_in   = vis_ff;
      rd_en    = 1'b0;
      rd_x     = wstat.x;
      rd_y     = wstat.y;
      rd_z     = wstat.z;
      wr_en    = 1'b0;
      wr_addr  = clr_ff;
      wr_data  = '0;
      wctl     = '0;
      rsp_load = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + row_addr_type'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               rd_en   = 1'b1;
               rd_x    = req_ch.ax;
               rd_y    = req_ch.ay;
               rd_z    = req_ch.az;
               bx_in   = req_ch.bx;
               by_in   = req_ch.by;
               bz_in   = req_ch.bz;
               wbit_in = req_ch.occupied_bit;
               if (req_ch.opcode == OP_QUERY) begin
                  chk_in    = 1'b1;
                  wctl.load = 1'b1;
                  state_in  = ST_Q_END;
               end else begin
                  state_in = ST_WR_MOD;
               end
            end
         end
         ST_WR_MOD: begin
            wr_en            = !oob_ff;
            wr_addr          = row_ff;
            wr_data          = rd_row;
            wr_data[xsel_ff] = wbit_ff;
            state_in         = ST_IDLE;
         end
         ST_Q_END: begin
            rd_en  = 1'b1;
            rd_x   = bx_ff;
            rd_y   = by_ff;
            rd_z   = bz_ff;
            chk_in = !hit;
            if (hit) begin
               vis_in   = 1'b0;
               state_in = ST_RESP;
            end else begin
               state_in = ST_Q_WALK;
            end
         end
         ST_Q_WALK: begin
            if (hit) begin
               vis_in   = 1'b0;
               state_in = ST_RESP;
            end else if (wstat.done) begin
               vis_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_en     = 1'b1;
               chk_in    = 1'b1;
               wctl.step = 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Tag the row read with its voxel
      if (rd_en) begin
         row_in  = rd_addr;
         xsel_in = rd_x;
         oob_in  = !in_grid(rd_x, rd_y, rd_z);
      end
   end

   // Response register: load a finished query, drop on transfer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_visible_in = rsp_visible_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_visible_in = vis_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bx_ff          <= bx_in;
      by_ff          <= by_in;
      bz_ff          <= bz_in;
      wbit_ff        <= wbit_in;
      row_ff         <= row_in;
      xsel_ff        <= xsel_in;
      oob_ff         <= oob_in;
      vis_ff         <= vis_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.visible = rsp_visible_ff;

endmodule

// ===== src/vlos_check.sv =====
// ============================================================================
// vlos_check
// Port-level checks of the line-of-sight core, bound to the top level.
// ============================================================================
module vlos_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible
);
   import vlos_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       q_acc;
   logic       r_acc;

   // Track queries whose response has not been transferred
   assign q_acc   = req_valid && req_ready && (req_opcode == OP_QUERY);
   assign r_acc   = rsp_valid && rsp_ready;
   assign pend_in = pend_ff + 2'(q_acc) - 2'(r_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Reset starts the clearing pass with both channels quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channels active right after reset");

   // Every response belongs to an accepted query
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding query");

   // A query drops req_ready right after it is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      q_acc |=> !req_ready)
      else $error("request taken during a query");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible))
      else $error("stalled response changed");

endmodule

bind voxel_line_of_sight_check_core vlos_check u_vlos_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_opcode  (req_ch.opcode),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_visible (rsp_ch.visible)
);
